/* hdl/cke_pkg.sv */
// Shared types and codes for the combo key expander.
package cke_pkg;

  typedef enum logic [1:0] {
    FUNC_KEY_EVENT  = 2'd0,
    FUNC_WR_TRIGGER = 2'd1,
    FUNC_WR_LENGTH  = 2'd2,
    FUNC_WR_SEQ_KEY = 2'd3
  } func_t;

  localparam logic [1:0] REG_COMBO_COUNT   = 2'd0;
  localparam logic [1:0] REG_MAC_MODE      = 2'd1;
  localparam logic [1:0] REG_MAC_EXEMPT    = 2'd2;

  typedef struct packed {
    func_t       func;
    logic [15:0] key_id;
    logic        pressed;
    logic [3:0]  combo_slot;
    logic [2:0]  seq_pos;
    logic [3:0]  seq_len;
  } item_t;

  typedef struct packed {
    logic [15:0] out_key_id;
    logic        out_pressed;
    logic        generated;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [4:0]  combo_count;
    logic        mac_mode;
    logic [15:0] mac_exempt_key;
  } cfg_t;

endpackage

/* hdl/cke_ram.sv */
// Generic simple dual-port RAM with registered read.
module cke_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/cke_regs.sv */
// APB configuration registers of the combo key expander.
module cke_regs
  import cke_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  logic wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_COMBO_COUNT: cfg.combo_count    <= pwdata[4:0];
        REG_MAC_MODE:    cfg.mac_mode       <= pwdata[0];
        REG_MAC_EXEMPT:  cfg.mac_exempt_key <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COMBO_COUNT: prdata = {27'd0, cfg.combo_count};
      REG_MAC_MODE:    prdata = {31'd0, cfg.mac_mode};
      REG_MAC_EXEMPT:  prdata = {16'd0, cfg.mac_exempt_key};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

/* hdl/cke_ctrl.sv */
// Table storage, binary search sequencer and sequence emitter.
module cke_ctrl
  import cke_pkg::*;
#(
  parameter int NUM_COMBOS = 16,
  parameter int MAX_SEQ    = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    busy,
  output logic    emit,
  output result_t emit_data
);

  localparam int IW  = (NUM_COMBOS > 1) ? $clog2(NUM_COMBOS) : 1;
  localparam int CW  = $clog2(NUM_COMBOS + 1);
  localparam int SD  = NUM_COMBOS * MAX_SEQ;
  localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
  localparam int PW  = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
  localparam int LW  = $clog2(MAX_SEQ + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_CMP    = 7'b0000100,
    S_LEN    = 7'b0001000,
    S_FETCH  = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_PASS   = 7'b1000000
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  lo, lo_next, hend, hend_next;
  logic [IW-1:0]  mid, mid_next;
  logic [15:0]    key, key_next;
  logic           pressed, pressed_next;
  logic [LW-1:0]  seq_n, seq_n_next, rem, rem_next;
  logic [PW-1:0]  rd_i, rd_i_next;

  logic           accept, slot_ok, pos_ok;
  logic [CW-1:0]  n_trig;
  logic [CW:0]    mid_sum;
  logic [IW-1:0]  mid_c;
  logic [IW-1:0]  wslot;
  logic [LW-1:0]  len_clamp, pos_l;
  logic [SAW-1:0] seq_waddr, seq_raddr;
  logic [15:0]    trig_rdata, seq_rdata;
  logic [3:0]     len_rdata;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign slot_ok = int'(item.combo_slot) < NUM_COMBOS;
  assign pos_ok  = int'(item.seq_pos) < MAX_SEQ;
  assign wslot   = IW'(item.combo_slot);
  assign seq_waddr = SAW'(wslot) * SAW'(MAX_SEQ) + SAW'(item.seq_pos);

  assign n_trig  = (int'(cfg.combo_count) > NUM_COMBOS) ? CW'(NUM_COMBOS)
                                                          : CW'(cfg.combo_count);
  // Middle of the live window, rounded down; hend is one past the last entry.
  assign mid_sum = {1'b0, lo} + {1'b0, hend} - (CW + 1)'(1);
  assign mid_c   = IW'(mid_sum[CW:1]);

  assign len_clamp = (int'(len_rdata) > MAX_SEQ) ? LW'(MAX_SEQ) : LW'(len_rdata);
  // Press walks the sequence forward, release walks it backward.
  assign pos_l     = pressed ? LW'(rd_i) : (seq_n - LW'(1) - LW'(rd_i));
  assign seq_raddr = SAW'(mid) * SAW'(MAX_SEQ) + SAW'(pos_l);

  cke_ram #(.WIDTH(16), .DEPTH(NUM_COMBOS)) u_trig_ram (
    .clk   (clk),
    .we    (accept && item.func == FUNC_WR_TRIGGER && slot_ok),
    .waddr (wslot),
    .wdata (item.key_id),
    .raddr (mid_c),
    .rdata (trig_rdata)
  );

  cke_ram #(.WIDTH(4), .DEPTH(NUM_COMBOS)) u_len_ram (
    .clk   (clk),
    .we    (accept && item.func == FUNC_WR_LENGTH && slot_ok),
    .waddr (wslot),
    .wdata (item.seq_len),
    .raddr (mid),
    .rdata (len_rdata)
  );

  cke_ram #(.WIDTH(16), .DEPTH(SD)) u_seq_ram (
    .clk   (clk),
    .we    (accept && item.func == FUNC_WR_SEQ_KEY && slot_ok && pos_ok),
    .waddr (seq_waddr),
    .wdata (item.key_id),
    .raddr (seq_raddr),
    .rdata (seq_rdata)
  );

  always_comb begin
    state_next   = state;
    lo_next      = lo;
    hend_next    = hend;
    mid_next     = mid;
    key_next     = key;
    pressed_next = pressed;
    seq_n_next   = seq_n;
    rem_next     = rem;
    rd_i_next    = rd_i;
    emit         = 1'b0;
    emit_data    = '0;
    case (state)
      S_IDLE: begin
        if (accept && item.func == FUNC_KEY_EVENT) begin
          key_next     = item.key_id;
          pressed_next = item.pressed;
          lo_next      = '0;
          hend_next    = n_trig;
          if (cfg.mac_mode && item.key_id == cfg.mac_exempt_key) begin
            state_next = S_PASS;
          end else begin
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (lo >= hend) begin
          state_next = S_PASS;
        end else begin
          mid_next   = mid_c;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (key == trig_rdata) begin
          state_next = S_LEN;
        end else if (key < trig_rdata) begin
          hend_next  = CW'(mid);
          state_next = S_SEARCH;
        end else begin
          lo_next    = CW'(mid) + CW'(1);
          state_next = S_SEARCH;
        end
      end
      S_LEN: begin
        seq_n_next = len_clamp;
        rem_next   = len_clamp;
        rd_i_next  = '0;
        state_next = (len_clamp == '0) ? S_IDLE : S_FETCH;
      end
      S_FETCH: begin
        rd_i_next  = rd_i + PW'(1);
        state_next = S_EMIT;
      end
      S_EMIT: begin
        emit                  = 1'b1;
        emit_data.out_key_id  = seq_rdata;
        emit_data.out_pressed = pressed;
        emit_data.generated   = 1'b1;
        emit_data.last        = (rem == LW'(1));
        rd_i_next             = rd_i + PW'(1);
        rem_next              = rem - LW'(1);
        if (rem == LW'(1)) begin
          state_next = S_IDLE;
        end
      end
      S_PASS: begin
        emit                  = 1'b1;
        emit_data.out_key_id  = key;
        emit_data.out_pressed = pressed;
        emit_data.generated   = 1'b0;
        emit_data.last        = 1'b1;
        state_next            = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    lo      <= lo_next;
    hend    <= hend_next;
    mid     <= mid_next;
    key     <= key_next;
    pressed <= pressed_next;
    seq_n   <= seq_n_next;
    rem     <= rem_next;
    rd_i    <= rd_i_next;
  end

endmodule

/* hdl/combo_key_expander.sv */
// Top level of the combo key expander: registers, sequencer and result register.
//
//   channel   signals                                  direction  transfer
//   item      start, busy, item                        in         start && !busy
//   result    strobe, result                           out        strobe, one cycle
//   config    psel, penable, pwrite, paddr, pwdata,    in/out     psel && penable
//             prdata, pready                                      && pwrite
//
// A table write finishes in the cycle it is accepted; busy stays low.
// A key event runs a binary search on one shared compare unit: each probe is a
// trigger RAM read followed by a compare, at most floor(log2(NUM_COMBOS))+1 probes.
// A match then reads the length, primes the sequence RAM read and emits the keys
// one by one; results leave from the output register in the cycle after they are
// emitted.
// Reset (rst, synchronous) clears the sequencer and the registers; the table
// memories are not cleared and must be written before use. Results cannot be
// stalled: each transaction is shown for exactly one cycle.
module combo_key_expander
  import cke_pkg::*;
#(
  parameter int NUM_COMBOS = 16,
  parameter int MAX_SEQ    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  item_t       item,
  output logic        busy,
  output logic        strobe,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  logic    emit;
  result_t emit_data;

  // Always ready, so an access is never extended.
  assign pready = 1'b1;

  cke_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  cke_ctrl #(.NUM_COMBOS(NUM_COMBOS), .MAX_SEQ(MAX_SEQ)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .cfg       (cfg),
    .busy      (busy),
    .emit      (emit),
    .emit_data (emit_data)
  );

  // Hold each result for one cycle in the output register; the strobe follows emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
    result <= emit_data;
  end

endmodule

/* hdl/cke_checker.sv */
// Port-level checks of the combo key expander and their bind.
module cke_checker
  import cke_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input item_t       item,
  input logic        busy,
  input logic        strobe,
  input result_t     result
);

  a_table_write_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.func != FUNC_KEY_EVENT |=> !busy && !strobe)
    else $error("table write left the block busy or produced a result");

  a_event_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.func == FUNC_KEY_EVENT |=> busy)
    else $error("key event did not start the sequencer");

  a_pass_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.generated |-> result.last)
    else $error("passed-through event not marked last");

  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe && result.generated
                               && result.out_pressed == $past(result.out_pressed))
    else $error("generated sequence broken before its last key");

endmodule

bind combo_key_expander cke_checker u_cke_checker (.*);
